// ===== hw/rtl/slte_pkg.sv =====
// types and constants shared by the sorted list table engine
package slte_pkg;

   localparam int TYPE_W    = 3;
   localparam int KEY_IN_W  = 16;
   localparam int POS_W     = 16;
   localparam int STATUS_W  = 3;
   localparam int IDX_OUT_W = 6;
   localparam int CNT_OUT_W = 7;
   localparam int BIT_W     = $clog2(POS_W);

   typedef enum logic [TYPE_W-1:0] {
      REQ_CLEAR   = 3'd0,
      REQ_ORD_INS = 3'd1,
      REQ_INS_AT  = 3'd2,
      REQ_REMOVE  = 3'd3,
      REQ_BSEARCH = 3'd4,
      REQ_SEQ     = 3'd5,
      REQ_READ    = 3'd6
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_BADPOS   = 3'd4
   } status_type;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_MOD   = 7'b0000010,
      S_FETCH = 7'b0000100,
      S_EVAL  = 7'b0001000,
      S_SHIFT = 7'b0010000,
      S_MOVE  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

endpackage

// ===== hw/rtl/slte_store.sv =====
// key store: one write port, one read port with registered read data
module slte_store #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sorted_list_table_engine.sv =====
// sorted list table engine: key store with count, inserts, removes and searches
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_type, req_key, req_position
//   rsp      out        rsp_valid/rsp_stall   rsp_status, rsp_index_out, rsp_key_out, rsp_count
//
// one item at a time; the store has a single read port, so every entry visited
// takes a fetch and an evaluate step and every entry moved takes a read and a write step
// ordered insert scans from the front and then moves the tail up, insert at moves the tail up,
// remove reduces the position modulo the count bit-serially and then moves the tail down
// synchronous reset clears the count and the control; the store is not cleared
// req_stall is high while an item is in flight; a stalled result holds in rsp regs
module sorted_list_table_engine #(
   parameter int MAX_ENTRIES = 64,
   parameter int KEY_WIDTH   = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [slte_pkg::TYPE_W-1:0]      req_type,
   input  logic [slte_pkg::KEY_IN_W-1:0]    req_key,
   input  logic [slte_pkg::POS_W-1:0]       req_position,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [slte_pkg::STATUS_W-1:0]    rsp_status,
   output logic [slte_pkg::IDX_OUT_W-1:0]   rsp_index_out,
   output logic [slte_pkg::KEY_IN_W-1:0]    rsp_key_out,
   output logic [slte_pkg::CNT_OUT_W-1:0]   rsp_count
);

   import slte_pkg::*;

   localparam int AW   = $clog2(MAX_ENTRIES);
   localparam int CW   = $clog2(MAX_ENTRIES + 1);
   localparam int CW1  = CW + 1;
   localparam int UW   = (KEY_WIDTH > CW1) ? KEY_WIDTH : CW1;
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   state_type             state_ff, state_in;
   logic [TYPE_W-1:0]     op_ff, op_in;
   logic [KEY_WIDTH-1:0]  key_ff, key_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [AW-1:0]         addr_ff, addr_in;
   logic [AW-1:0]         ins_ff, ins_in;
   logic [CW-1:0]         lo_ff, lo_in;
   logic [CW-1:0]         hi_ff, hi_in;
   logic [CW-1:0]         rem_ff, rem_in;
   logic [BIT_W-1:0]      bit_ff, bit_in;
   logic [CW-1:0]         count_ff, count_in;
   status_type            res_status_ff, res_status_in;
   logic [AW-1:0]         res_idx_ff, res_idx_in;
   logic [KEY_WIDTH-1:0]  res_key_ff, res_key_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [IDX_OUT_W-1:0]  rsp_index_out_ff, rsp_index_out_in;
   logic [KEY_IN_W-1:0]   rsp_key_out_ff, rsp_key_out_in;
   logic [CNT_OUT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [KEY_WIDTH-1:0]  mem_wdata;
   logic [AW-1:0]         rd_addr;
   logic [KEY_WIDTH-1:0]  rd_data;

   logic [UW-1:0]         op_a, op_b;
   logic [UW:0]           diff;
   logic                  alu_lt, alu_eq;

   logic [CW:0]           rem_sh;
   logic [CW-1:0]         rem_next;
   logic [CW:0]           mid_sum;
   logic [AW-1:0]         mid;
   logic [CW:0]           addr_inc;
   logic                  addr_last;
   logic                  accept, load;
   logic                  cnt_full, cnt_zero, pos_gt_cnt, pos_ge_cnt;

   slte_store #(
      .DEPTH (MAX_ENTRIES),
      .WIDTH (KEY_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared subtract and compare unit
   assign rem_sh = {rem_ff, pos_ff[POS_W-1]};

   always_comb begin
      if (state_ff == S_MOD) begin
         op_a = UW'(rem_sh);
         op_b = UW'(count_ff);
      end else begin
         op_a = UW'(key_ff);
         op_b = UW'(rd_data);
      end
      diff   = {1'b0, op_a} - {1'b0, op_b};
      alu_lt = diff[UW];
      alu_eq = (diff == '0);
   end

   assign rem_next   = alu_lt ? rem_sh[CW-1:0] : diff[CW-1:0];
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid        = AW'(mid_sum[CW:1]);
   assign addr_inc   = CW1'(addr_ff) + CW1'(1);
   assign addr_last  = (addr_inc == CW1'(count_ff));

   assign cnt_full   = (count_ff == CW'(MAX_ENTRIES));
   assign cnt_zero   = (count_ff == '0);
   assign pos_gt_cnt = (CMPW'(req_position) > CMPW'(count_ff));
   assign pos_ge_cnt = (CMPW'(req_position) >= CMPW'(count_ff));

   assign req_stall  = (state_ff != S_IDLE);
   assign accept     = req_valid && !req_stall;
   assign load       = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      addr_in       = addr_ff;
      ins_in        = ins_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      rem_in        = rem_ff;
      bit_in        = bit_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_key_in    = res_key_ff;
      mem_we        = 1'b0;
      mem_waddr     = addr_ff;
      mem_wdata     = rd_data;
      rd_addr       = addr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in         = req_type;
               key_in        = KEY_WIDTH'(req_key);
               pos_in        = req_position;
               res_status_in = ST_OK;
               res_idx_in    = '0;
               res_key_in    = '0;
               state_in      = S_DONE;
               unique case (req_type)
                  REQ_CLEAR: begin
                     count_in = '0;
                  end
                  REQ_ORD_INS: begin
                     if (cnt_full) begin
                        res_status_in = ST_FULL;
                     end else if (cnt_zero) begin
                        addr_in  = '0;
                        ins_in   = '0;
                        state_in = S_SHIFT;
                     end else begin
                        addr_in  = '0;
                        state_in = S_FETCH;
                     end
                  end
                  REQ_INS_AT: begin
                     if (cnt_full) begin
                        res_status_in = ST_FULL;
                     end else if (pos_gt_cnt) begin
                        res_status_in = ST_BADPOS;
                     end else begin
                        addr_in  = AW'(count_ff);
                        ins_in   = AW'(req_position);
                        state_in = S_SHIFT;
                     end
                  end
                  REQ_REMOVE: begin
                     if (cnt_zero) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        rem_in   = '0;
                        bit_in   = '1;
                        state_in = S_MOD;
                     end
                  end
                  REQ_BSEARCH: begin
                     if (cnt_zero) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        lo_in    = '0;
                        hi_in    = count_ff - CW'(1);
                        state_in = S_FETCH;
                     end
                  end
                  REQ_SEQ: begin
                     if (cnt_zero) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        addr_in  = '0;
                        state_in = S_FETCH;
                     end
                  end
                  REQ_READ: begin
                     if (cnt_zero) begin
                        res_status_in = ST_EMPTY;
                     end else if (pos_ge_cnt) begin
                        res_status_in = ST_BADPOS;
                     end else begin
                        addr_in  = AW'(req_position);
                        state_in = S_FETCH;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         // restoring remainder, one position bit a cycle
         S_MOD: begin
            rem_in = rem_next;
            pos_in = pos_ff << 1;
            bit_in = bit_ff - BIT_W'(1);
            if (bit_ff == '0) begin
               addr_in  = AW'(rem_next);
               state_in = S_FETCH;
            end
         end

         S_FETCH: begin
            if (op_ff == REQ_BSEARCH) begin
               rd_addr = mid;
               addr_in = mid;
            end
            state_in = S_EVAL;
         end

         S_EVAL: begin
            unique case (op_ff)
               REQ_ORD_INS: begin
                  if (alu_lt) begin
                     ins_in   = addr_ff;
                     addr_in  = AW'(count_ff);
                     state_in = S_SHIFT;
                  end else if (addr_last) begin
                     ins_in   = AW'(count_ff);
                     addr_in  = AW'(count_ff);
                     state_in = S_SHIFT;
                  end else begin
                     addr_in  = AW'(addr_inc);
                     state_in = S_FETCH;
                  end
               end
               REQ_SEQ: begin
                  if (alu_eq) begin
                     res_idx_in = addr_ff;
                     res_key_in = rd_data;
                     state_in   = S_DONE;
                  end else if (addr_last) begin
                     res_status_in = ST_NOTFOUND;
                     state_in      = S_DONE;
                  end else begin
                     addr_in  = AW'(addr_inc);
                     state_in = S_FETCH;
                  end
               end
               REQ_BSEARCH: begin
                  if (alu_eq) begin
                     res_idx_in = addr_ff;
                     res_key_in = rd_data;
                     state_in   = S_DONE;
                  end else if (alu_lt) begin
                     if (CW'(addr_ff) == lo_ff) begin
                        res_status_in = ST_NOTFOUND;
                        state_in      = S_DONE;
                     end else begin
                        hi_in    = CW'(addr_ff) - CW'(1);
                        state_in = S_FETCH;
                     end
                  end else begin
                     if (CW'(addr_ff) == hi_ff) begin
                        res_status_in = ST_NOTFOUND;
                        state_in      = S_DONE;
                     end else begin
                        lo_in    = CW'(addr_inc);
                        state_in = S_FETCH;
                     end
                  end
               end
               REQ_READ: begin
                  res_idx_in = addr_ff;
                  res_key_in = rd_data;
                  state_in   = S_DONE;
               end
               REQ_REMOVE: begin
                  res_idx_in = addr_ff;
                  res_key_in = rd_data;
                  state_in   = S_SHIFT;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         S_SHIFT: begin
            if (op_ff == REQ_REMOVE) begin
               if (addr_inc < CW1'(count_ff)) begin
                  rd_addr  = AW'(addr_inc);
                  state_in = S_MOVE;
               end else begin
                  count_in = count_ff - CW'(1);
                  state_in = S_DONE;
               end
            end else begin
               if (addr_ff > ins_ff) begin
                  rd_addr  = addr_ff - AW'(1);
                  state_in = S_MOVE;
               end else begin
                  mem_we     = 1'b1;
                  mem_waddr  = ins_ff;
                  mem_wdata  = key_ff;
                  count_in   = count_ff + CW'(1);
                  res_idx_in = ins_ff;
                  res_key_in = key_ff;
                  state_in   = S_DONE;
               end
            end
         end

         S_MOVE: begin
            mem_we    = 1'b1;
            mem_waddr = addr_ff;
            mem_wdata = rd_data;
            if (op_ff == REQ_REMOVE) begin
               addr_in = AW'(addr_inc);
            end else begin
               addr_in = addr_ff - AW'(1);
            end
            state_in = S_SHIFT;
         end

         S_DONE: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in     = load || (rsp_valid_ff && rsp_stall);
      rsp_status_in    = rsp_status_ff;
      rsp_index_out_in = rsp_index_out_ff;
      rsp_key_out_in   = rsp_key_out_ff;
      rsp_count_in     = rsp_count_ff;
      if (load) begin
         rsp_status_in    = res_status_ff;
         rsp_index_out_in = IDX_OUT_W'(res_idx_ff);
         rsp_key_out_in   = KEY_IN_W'(res_key_ff);
         rsp_count_in     = CNT_OUT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      key_ff           <= key_in;
      pos_ff           <= pos_in;
      addr_ff          <= addr_in;
      ins_ff           <= ins_in;
      lo_ff            <= lo_in;
      hi_ff            <= hi_in;
      rem_ff           <= rem_in;
      bit_ff           <= bit_in;
      res_status_ff    <= res_status_in;
      res_idx_ff       <= res_idx_in;
      res_key_ff       <= res_key_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_index_out_ff <= rsp_index_out_in;
      rsp_key_out_ff   <= rsp_key_out_in;
      rsp_count_ff     <= rsp_count_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_index_out = rsp_index_out_ff;
   assign rsp_key_out   = rsp_key_out_ff;
   assign rsp_count     = rsp_count_ff;

endmodule
